FILE: rtl/core/hws_pkg.sv
package hws_pkg;

  localparam int FRACTION_BITS = 53;
  localparam int LEN_W         = 26;
  localparam int RAW_W         = LEN_W + 1;
  localparam int ID_W          = 32;
  localparam int IDX_W         = 64;
  localparam int SEED_W        = 64;
  localparam int MODE_W        = 2;
  localparam int CFG_W         = SEED_W;
  localparam int CFG_IDX_W     = 3;
  localparam int ORG_W         = 2;

  localparam int PROD_W  = FRACTION_BITS + LEN_W;
  localparam int NUM_W   = 2 * LEN_W + FRACTION_BITS;
  localparam int QUO_W   = LEN_W + 1;
  localparam int R_LO_W  = (FRACTION_BITS + 1) / 2;
  localparam int R_HI_W  = FRACTION_BITS - R_LO_W;

  localparam int TOP_STAGES = 10;

  localparam logic [63:0] GOLDEN = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] MIX_A  = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] MIX_B  = 64'h94d0_49bb_1331_11eb;

  localparam logic [ID_W-1:0] OFS_SHOWER = 32'd1000003;
  localparam logic [ID_W-1:0] OFS_ARRAY  = 32'd100003;
  localparam logic [ID_W-1:0] OFS_TEL    = 32'd10007;

  localparam logic [MODE_W-1:0] MODE_FIXED   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UNIFORM = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INVSQ   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE   = 2'd3;

  localparam logic [ORG_W-1:0] ORG_RAW = 2'd0;
  localparam logic [ORG_W-1:0] ORG_DEF = 2'd1;
  localparam logic [ORG_W-1:0] ORG_SMP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEED    = 3'd4;

  localparam logic [LEN_W-1:0] RST_DEFAULT = 26'd26214400;
  localparam logic [LEN_W-1:0] RST_MIN     = 26'd19660800;
  localparam logic [LEN_W-1:0] RST_MAX     = 26'd39321600;

  typedef struct packed {
    logic [LEN_W-1:0] wl;
    logic [ORG_W-1:0] origin;
    logic             err;
    logic             smp;
    logic             inv;
  } res_t;

  typedef struct packed {
    res_t             res;
    logic [NUM_W-1:0] num;
    logic [NUM_W-1:0] den;
    logic [QUO_W-1:0] q;
  } div_t;

  function automatic logic [63:0] combine(input logic [63:0] s, input logic [63:0] v);
    combine = s ^ (v + GOLDEN + (s << 6) + (s >> 2));
  endfunction

  function automatic logic [63:0] id_term(input logic [ID_W-1:0] id,
                                          input logic [ID_W-1:0] ofs);
    logic [ID_W-1:0] sum;
    sum = id + ofs;
    id_term = {{(64 - ID_W){sum[ID_W-1]}}, sum};
  endfunction

endpackage

FILE: rtl/core/hashed_wavelength_sampler.sv
// Photon wavelength resolver.
// Input channel in_*: one photon per item (stored wavelength, three ids,
// bunch and photon index), taken when in_valid is high and in_stall low.
// Result channel out_*: one item per input, in order, taken when out_valid
// is high and out_stall low. Positive stored values pass through, placeholders
// give the default, and missing values give the default in fixed or spare mode
// and are otherwise sampled from a hash of seed and ids. The path runs through
// ten hash, mix and multiply stages and a 27-stage restoring divider, one
// quotient bit a stage. Throughput: one item per cycle while out_stall is low.
// Configuration through cfg_we/cfg_idx/cfg_data, only while the block is idle.
// Reset clears all valid bits and loads the register defaults (fixed mode,
// 400 nm default, 300 to 600 nm range, zero seed).
// When out_stall is high the last stage holds; stages behind it keep filling
// empty slots, and in_stall rises only once every stage holds an item.
module hashed_wavelength_sampler (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_we,
  input  logic [hws_pkg::CFG_IDX_W-1:0]            cfg_idx,
  input  logic [hws_pkg::CFG_W-1:0]                cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [hws_pkg::RAW_W-1:0]         in_raw_length,
  input  logic signed [hws_pkg::ID_W-1:0]          in_shower_id,
  input  logic signed [hws_pkg::ID_W-1:0]          in_array_number,
  input  logic signed [hws_pkg::ID_W-1:0]          in_telescope_number,
  input  logic [hws_pkg::IDX_W-1:0]                in_bunch_number,
  input  logic [hws_pkg::IDX_W-1:0]                in_photon_number,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic [hws_pkg::LEN_W-1:0]                out_wavelength,
  output logic [hws_pkg::ORG_W-1:0]                out_origin_code,
  output logic                                     out_bounds_error
);
  import hws_pkg::*;

  typedef struct packed {
    res_t             res;
    logic [63:0]      s;
    logic [3:0][63:0] v;
  } hash_t;

  typedef struct packed {
    res_t        res;
    logic [63:0] p00;
    logic [31:0] p01;
    logic [31:0] p10;
  } mul_t;

  typedef struct packed {
    res_t                     res;
    logic [FRACTION_BITS-1:0] r;
  } rnd_t;

  typedef struct packed {
    res_t                      res;
    logic [R_LO_W+LEN_W-1:0]   pl;
    logic [R_HI_W+LEN_W-1:0]   ph;
    logic [2*LEN_W-1:0]        mm;
  } prd_t;

  logic [MODE_W-1:0] mode_r;
  logic [LEN_W-1:0]  default_r;
  logic [LEN_W-1:0]  min_r;
  logic [LEN_W-1:0]  max_r;
  logic [SEED_W-1:0] seed_r;

  logic [TOP_STAGES-1:0] vld_r;
  logic [TOP_STAGES:0]   rdy;
  hash_t                 h_r [5];
  mul_t                  f1_r;
  mul_t                  f2_r;
  rnd_t                  f3_r;
  prd_t                  m1_r;
  div_t                  m2_r;

  hash_t h0_nxt;
  mul_t  f1_nxt;
  mul_t  f2_nxt;
  rnd_t  f3_nxt;
  prd_t  m1_nxt;
  div_t  m2_nxt;

  logic  div_rdy;
  logic  div_vld;
  div_t  div_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_FIXED;
      default_r <= RST_DEFAULT;
      min_r     <= RST_MIN;
      max_r     <= RST_MAX;
      seed_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MODE:    mode_r    <= cfg_data[MODE_W-1:0];
        REG_DEFAULT: default_r <= cfg_data[LEN_W-1:0];
        REG_MIN:     min_r     <= cfg_data[LEN_W-1:0];
        REG_MAX:     max_r     <= cfg_data[LEN_W-1:0];
        REG_SEED:    seed_r    <= cfg_data;
        default:     ;
      endcase
    end
  end

  assign rdy[TOP_STAGES] = div_rdy;
  assign in_stall        = !rdy[0];

  for (genvar i = 0; i < TOP_STAGES; i++) begin : g_ctl
    assign rdy[i] = !vld_r[i] || rdy[i+1];
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld_r[i] <= (i == 0) ? in_valid : vld_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  always_comb begin
    h0_nxt     = '0;
    h0_nxt.res = '0;
    if (in_raw_length != '0 && !in_raw_length[RAW_W-1]) begin
      h0_nxt.res.wl     = in_raw_length[LEN_W-1:0];
      h0_nxt.res.origin = ORG_RAW;
    end else if (in_raw_length != '0 || mode_r == MODE_FIXED || mode_r == MODE_SPARE) begin
      h0_nxt.res.wl     = default_r;
      h0_nxt.res.origin = ORG_DEF;
    end else if (min_r == '0 || max_r <= min_r) begin
      h0_nxt.res.origin = ORG_SMP;
      h0_nxt.res.err    = 1'b1;
    end else begin
      h0_nxt.res.origin = ORG_SMP;
      h0_nxt.res.smp    = 1'b1;
      h0_nxt.res.inv    = (mode_r == MODE_INVSQ);
    end
    h0_nxt.s    = combine(seed_r, id_term(in_shower_id, OFS_SHOWER));
    h0_nxt.v[0] = id_term(in_array_number, OFS_ARRAY);
    h0_nxt.v[1] = id_term(in_telescope_number, OFS_TEL);
    h0_nxt.v[2] = in_bunch_number + 64'd1;
    h0_nxt.v[3] = in_photon_number + 64'd1;
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      h_r[0] <= h0_nxt;
    end
  end

  for (genvar k = 1; k < 5; k++) begin : g_hash
    hash_t nxt;
    always_comb begin
      nxt   = h_r[k-1];
      nxt.s = combine(h_r[k-1].s, h_r[k-1].v[k-1]);
    end
    always_ff @(posedge clk) begin
      if (rdy[k] && vld_r[k-1]) begin
        h_r[k] <= nxt;
      end
    end
  end

  always_comb begin
    logic [63:0] x;
    logic [63:0] y;
    x          = h_r[4].s + GOLDEN;
    y          = x ^ (x >> 30);
    f1_nxt.res = h_r[4].res;
    f1_nxt.p00 = 64'(y[31:0]) * 64'(MIX_A[31:0]);
    f1_nxt.p01 = 32'(y[31:0] * MIX_A[63:32]);
    f1_nxt.p10 = 32'(y[63:32] * MIX_A[31:0]);
  end

  always_comb begin
    logic [63:0] z;
    logic [63:0] y;
    z          = f1_r.p00 + {f1_r.p01 + f1_r.p10, 32'b0};
    y          = z ^ (z >> 27);
    f2_nxt.res = f1_r.res;
    f2_nxt.p00 = 64'(y[31:0]) * 64'(MIX_B[31:0]);
    f2_nxt.p01 = 32'(y[31:0] * MIX_B[63:32]);
    f2_nxt.p10 = 32'(y[63:32] * MIX_B[31:0]);
  end

  always_comb begin
    logic [63:0] w;
    logic [63:0] f;
    w          = f2_r.p00 + {f2_r.p01 + f2_r.p10, 32'b0};
    f          = w ^ (w >> 31);
    f3_nxt.res = f2_r.res;
    f3_nxt.r   = f[63 -: FRACTION_BITS];
    if (f3_nxt.r == '0) begin
      f3_nxt.r = FRACTION_BITS'(1);
    end
  end

  always_comb begin
    logic [LEN_W-1:0] span;
    span       = max_r - min_r;
    m1_nxt.res = f3_r.res;
    m1_nxt.pl  = (R_LO_W+LEN_W)'(f3_r.r[R_LO_W-1:0]) * (R_LO_W+LEN_W)'(span);
    m1_nxt.ph  = (R_HI_W+LEN_W)'(f3_r.r[FRACTION_BITS-1:R_LO_W]) *
                 (R_HI_W+LEN_W)'(span);
    m1_nxt.mm  = (2*LEN_W)'(min_r) * (2*LEN_W)'(max_r);
  end

  always_comb begin
    logic [PROD_W-1:0] prod;
    prod       = {m1_r.ph, {R_LO_W{1'b0}}} + PROD_W'(m1_r.pl);
    m2_nxt.res = m1_r.res;
    if (m1_r.res.smp && !m1_r.res.inv) begin
      m2_nxt.res.wl = min_r + prod[PROD_W-1:FRACTION_BITS];
    end
    m2_nxt.num = {m1_r.mm, {FRACTION_BITS{1'b0}}};
    m2_nxt.den = NUM_W'({max_r, {FRACTION_BITS{1'b0}}}) - NUM_W'(prod);
    m2_nxt.q   = '0;
  end

  always_ff @(posedge clk) begin
    if (rdy[5] && vld_r[4]) f1_r <= f1_nxt;
    if (rdy[6] && vld_r[5]) f2_r <= f2_nxt;
    if (rdy[7] && vld_r[6]) f3_r <= f3_nxt;
    if (rdy[8] && vld_r[7]) m1_r <= m1_nxt;
    if (rdy[9] && vld_r[8]) m2_r <= m2_nxt;
  end

  hws_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld_r[TOP_STAGES-1]),
    .in_rdy   (div_rdy),
    .in_item  (m2_r),
    .out_vld  (div_vld),
    .out_rdy  (!out_stall),
    .out_item (div_out)
  );

  assign out_valid        = div_vld;
  assign out_wavelength   = (div_out.res.smp && div_out.res.inv) ?
                            div_out.q[LEN_W-1:0] : div_out.res.wl;
  assign out_origin_code  = div_out.res.origin;
  assign out_bounds_error = div_out.res.err;

  a_err_origin : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bounds_error |-> out_origin_code == ORG_SMP)
    else $error("bounds error on a result that was not sampled");

  a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bounds_error |-> out_wavelength == '0)
    else $error("bounds error with nonzero wavelength");

  a_origin_code : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_origin_code == ORG_RAW || out_origin_code == ORG_DEF ||
                  out_origin_code == ORG_SMP)
    else $error("undefined origin code");

  a_smp_clean : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && div_out.res.smp |-> !out_bounds_error && out_origin_code == ORG_SMP)
    else $error("sampled result carries wrong flags");

endmodule

FILE: rtl/core/hws_div.sv
module hws_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  output logic          in_rdy,
  input  hws_pkg::div_t in_item,
  output logic          out_vld,
  input  logic          out_rdy,
  output hws_pkg::div_t out_item
);
  import hws_pkg::*;

  logic [QUO_W-1:0] vld_r;
  div_t             st_r [QUO_W];
  logic [QUO_W:0]   rdy;

  assign rdy[QUO_W] = out_rdy;
  assign in_rdy     = rdy[0];
  assign out_vld    = vld_r[QUO_W-1];
  assign out_item   = st_r[QUO_W-1];

  for (genvar i = 0; i < QUO_W; i++) begin : g_step
    div_t             src;
    div_t             nxt;
    logic             src_v;
    logic [NUM_W-1:0] t;

    if (i == 0) begin : g_first
      assign src   = in_item;
      assign src_v = in_vld;
    end else begin : g_next
      assign src   = st_r[i-1];
      assign src_v = vld_r[i-1];
    end

    assign rdy[i] = !vld_r[i] || rdy[i+1];

    always_comb begin
      t   = src.den << (QUO_W - 1 - i);
      nxt = src;
      if (t <= src.num) begin
        nxt.num               = src.num - t;
        nxt.q[QUO_W - 1 - i]  = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        vld_r[i] <= src_v;
      end
      if (rdy[i] && src_v) begin
        st_r[i] <= nxt;
      end
    end
  end

endmodule
